// ===== rtl/fpfa_pkg.sv =====
// shared types and constants of the fixed partition fit allocator
`default_nettype none

package fpfa_pkg;

   // default sizing of the partition table
   localparam int NUM_BLOCKS_DEFAULT = 64;
   localparam int SIZE_BITS_DEFAULT  = 16;

   // transaction field widths
   localparam int CMD_W   = 1;
   localparam int BIDX_W  = 6;
   localparam int RSIZE_W = 16;
   localparam int PID_W   = 6;
   localparam int COUNT_W = 7;
   localparam int MODE_W  = 2;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD    = 1'd0;
   localparam logic [CMD_W-1:0] CMD_REQUEST = 1'd1;

   // placement policies
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd2;

   // saturation value of the grant counter
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // control from the sequencer to the candidate tracker
   typedef struct packed {
      logic restart;
      logic sample;
   } scan_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/fpfa_if.sv =====
// valid/ready channel interfaces for request and response transactions
`default_nettype none

interface fpfa_req_if
   import fpfa_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [BIDX_W-1:0]  block_index;
   logic [RSIZE_W-1:0] request_size;
   logic [PID_W-1:0]   process_id;

   modport source (output valid, command, block_index, request_size, process_id,
                   input ready);
   modport sink   (input valid, command, block_index, request_size, process_id,
                   output ready);
endinterface

interface fpfa_rsp_if
   import fpfa_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               granted;
   logic [BIDX_W-1:0]  chosen_block;
   logic [PID_W-1:0]   owner_process;
   logic [COUNT_W-1:0] allocated_count;

   modport source (output valid, granted, chosen_block, owner_process, allocated_count,
                   input ready);
   modport sink   (input valid, granted, chosen_block, owner_process, allocated_count,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/fixed_partition_fit_allocator.sv =====
// Fixed partition fit allocator, top level.
//
// Input channel req_ch carries load and request transactions. A load writes
// one partition's size and marks it free; it gives no response. A request
// is placed by fit_mode (worst, best or first fit) and gives exactly one
// response on rsp_ch: grant flag, chosen partition, owner and the running
// grant count.
// A request reads the partition table one entry per cycle from a single
// read port, min(block_count, NUM_BLOCKS) entries. After it is taken the
// block steps through one read per partition, the last read returning, a
// settle step and the decide step. Only one request is in flight; the next
// transaction is taken once the decide step has finished, after writing the
// chosen partition back on a grant.
// The response sits in an output register; the block takes new transactions
// while it waits. If the receiver stalls and another response is ready, the
// decide cycle holds until the register frees up.
// After reset a clearing pass writes every table entry free; req_ch is not
// ready meanwhile, csr writes are taken throughout. Configuration is to be
// written through csr_* while the block is idle; the block does not check.
`default_nettype none

module fixed_partition_fit_allocator
   import fpfa_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = SIZE_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   fpfa_req_if.sink                   req_ch,
   fpfa_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int WORD_W = SIZE_BITS + 1;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [LIM_W-1:0]     addr_ff, addr_in;
   logic [LIM_W-1:0]     limit_ff;
   logic                 rd_valid_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [SIZE_BITS-1:0] need_ff;
   logic [PID_W-1:0]     pid_ff;
   logic [MODE_W-1:0]    fit_mode_ff;
   logic [COUNT_W-1:0]   block_count_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_granted_ff;
   logic [BIDX_W-1:0]    rsp_block_ff;
   logic [PID_W-1:0]     rsp_owner_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 accept;
   logic                 is_load;
   logic                 load_in_range;
   logic [31:0]          load_idx_wide;
   logic [47:0]          size_wide;
   logic [SIZE_BITS-1:0] size_in;
   logic [LIM_W-1:0]     count_ext;
   logic [LIM_W-1:0]     num_ext;
   logic [LIM_W-1:0]     limit_in;
   logic                 issuing;
   logic                 decide_go;
   logic                 grant;
   logic [31:0]          best_idx_wide;

   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   logic [WORD_W-1:0]    mem_wr_data;
   logic [WORD_W-1:0]    mem_rd_data;

   scan_ctl_type         scan_ctl;
   logic                 found;
   logic [IDX_W-1:0]     best_idx;
   logic [SIZE_BITS-1:0] best_size;

   // input transaction decode
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign accept        = req_ch.valid && req_ch.ready;
   assign is_load       = (req_ch.command == CMD_LOAD);
   assign load_idx_wide = 32'(req_ch.block_index);
   assign load_in_range = (load_idx_wide < 32'(NUM_BLOCKS));
   assign size_wide     = 48'(req_ch.request_size);
   assign size_in       = size_wide[SIZE_BITS-1:0];

   // partitions in use, clamped to the table depth
   assign count_ext = LIM_W'(block_count_ff);
   assign num_ext   = LIM_W'(NUM_BLOCKS);
   assign limit_in  = (count_ext > num_ext) ? num_ext : count_ext;

   // scan address issue and commit conditions
   assign issuing   = (state_ff == ST_SCAN) && (addr_ff < limit_ff);
   assign decide_go = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ch.ready);
   assign grant     = found && (best_size >= need_ff);

   // memory write port: clearing pass, loads, commit of a grant
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_ff;
      mem_wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en = 1'b1;
      end else if (accept && is_load) begin
         mem_wr_en   = load_in_range;
         mem_wr_addr = load_idx_wide[IDX_W-1:0];
         mem_wr_data = {1'b0, size_in};
      end else if (decide_go && grant) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = best_idx;
         mem_wr_data = {1'b1, best_size};
      end
   end

   fpfa_mem #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (WORD_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (issuing),
      .rd_addr    (addr_ff[IDX_W-1:0]),
      .rd_data_ff (mem_rd_data)
   );

   // candidate tracking on returned entries
   assign scan_ctl.restart = accept && !is_load;
   assign scan_ctl.sample  = rd_valid_ff;

   fpfa_scan #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_scan (
      .clock        (clock),
      .ctl          (scan_ctl),
      .fit_mode     (fit_mode_ff),
      .need         (need_ff),
      .entry_used   (mem_rd_data[WORD_W-1]),
      .entry_size   (mem_rd_data[SIZE_BITS-1:0]),
      .entry_idx    (rd_idx_ff),
      .found_ff     (found),
      .best_idx_ff  (best_idx),
      .best_size_ff (best_size)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            addr_in = '0;
            if (accept && !is_load) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               addr_in = addr_ff + 1'b1;
            end else if (!rd_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (decide_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // saturating grant counter
   always_comb begin
      count_in = count_ff;
      if (decide_go && grant && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rd_valid_ff    <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         fit_mode_ff    <= MODE_WORST;
         block_count_ff <= COUNT_W'(64);
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         rd_valid_ff <= issuing;
         count_ff    <= count_in;
         if (decide_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en && (csr_index == CSR_FIT_MODE)) begin
            fit_mode_ff <= csr_write_data[MODE_W-1:0];
         end
         if (csr_write_en && (csr_index == CSR_BLOCK_COUNT)) begin
            block_count_ff <= csr_write_data[COUNT_W-1:0];
         end
      end
   end

   // request payload and scan index registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (issuing) begin
         rd_idx_ff <= addr_ff[IDX_W-1:0];
      end
      if (accept && !is_load) begin
         need_ff  <= size_in;
         pid_ff   <= req_ch.process_id;
         limit_ff <= limit_in;
      end
   end

   // response register
   assign best_idx_wide = 32'(best_idx);

   always_ff @(posedge clock) begin
      if (decide_go) begin
         rsp_granted_ff <= grant;
         rsp_block_ff   <= grant ? best_idx_wide[BIDX_W-1:0] : '0;
         rsp_owner_ff   <= grant ? pid_ff : '0;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.granted         = rsp_granted_ff;
   assign rsp_ch.chosen_block    = rsp_block_ff;
   assign rsp_ch.owner_process   = rsp_owner_ff;
   assign rsp_ch.allocated_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/fpfa_mem.sv =====
// partition table memory: one write port, one registered read port
`default_nettype none

module fpfa_mem
   import fpfa_pkg::*;
#(
   parameter int DEPTH = NUM_BLOCKS_DEFAULT,
   parameter int WIDTH = SIZE_BITS_DEFAULT + 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fpfa_scan.sv =====
// candidate tracker: keeps the best partition seen so far under the active policy
`default_nettype none

module fpfa_scan
   import fpfa_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = SIZE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire scan_ctl_type                  ctl,
   input  wire logic [MODE_W-1:0]             fit_mode,
   input  wire logic [SIZE_BITS-1:0]          need,
   input  wire logic                          entry_used,
   input  wire logic [SIZE_BITS-1:0]          entry_size,
   input  wire logic [$clog2(NUM_BLOCKS)-1:0] entry_idx,
   output logic                               found_ff,
   output logic      [$clog2(NUM_BLOCKS)-1:0] best_idx_ff,
   output logic      [SIZE_BITS-1:0]          best_size_ff
);

   logic fits;
   logic take;

   // policy compare on the entry just read
   always_comb begin
      fits = (entry_size >= need);
      take = 1'b0;
      if (!entry_used) begin
         case (fit_mode)
            MODE_WORST: take = !found_ff || (entry_size > best_size_ff);
            MODE_BEST:  take = fits && (!found_ff || (entry_size < best_size_ff));
            MODE_FIRST: take = fits && !found_ff;
            default:    take = 1'b0;
         endcase
      end
   end

   // best candidate registers
   always_ff @(posedge clock) begin
      if (ctl.restart) begin
         found_ff <= 1'b0;
      end else if (ctl.sample && take) begin
         found_ff <= 1'b1;
      end
      if (ctl.sample && take) begin
         best_idx_ff  <= entry_idx;
         best_size_ff <= entry_size;
      end
   end

endmodule

`default_nettype wire

// ===== verif/fixed_partition_fit_allocator_tb.sv =====
// self-checking testbench of the fixed partition fit allocator
module fixed_partition_fit_allocator_tb
   import fpfa_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PARTS        = NUM_BLOCKS_DEFAULT;
   localparam int DRAIN_CYCLES     = NUM_PARTS + 3 + 13;
   localparam int STALL_LIMIT      = 4000;
   localparam int HOLD_CYCLES      = 600;
   localparam int HOLD_AFTER       = 150;
   localparam int PHASES           = 14;
   localparam int ITEMS_PER_PHASE  = 140;
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [BIDX_W-1:0]  block_index;
      logic [RSIZE_W-1:0] request_size;
      logic [PID_W-1:0]   process_id;
   } alloc_item_type;

   typedef struct packed {
      logic               granted;
      logic [BIDX_W-1:0]  chosen_block;
      logic [PID_W-1:0]   owner_process;
      logic [COUNT_W-1:0] allocated_count;
   } placement_type;

   // one line of the directed table: a register write or a transaction
   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      alloc_item_type        item;
      logic                  literal_check;
      placement_type         literal_result;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   fpfa_req_if req_if ();
   fpfa_rsp_if rsp_if ();

   fixed_partition_fit_allocator dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // shadow copy of the partition table and the configuration
   logic [RSIZE_W-1:0] part_size    [NUM_PARTS];
   logic               part_used    [NUM_PARTS];
   logic               part_written [NUM_PARTS];
   logic [COUNT_W-1:0] grant_total;
   logic [MODE_W-1:0]  cfg_mode;
   logic [6:0]         cfg_count;

   placement_type expected_placements[$];
   stim_row_type  directed_rows[$];

   int  fail_count;
   int  results_seen;
   int  n_loads;
   int  n_requests;
   int  n_granted;
   int  n_settings;
   int  stall_left;
   bit  calm;
   bit  hold_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // placement policy of the block, applied to the shadow table
   function automatic placement_type predict_placement(logic [RSIZE_W-1:0] need,
                                                       logic [PID_W-1:0] pid);
      int                 limit;
      int                 i;
      bit                 found;
      int                 pick;
      logic [RSIZE_W-1:0] pick_size;
      placement_type      res;
      limit = (cfg_count > NUM_PARTS) ? NUM_PARTS : int'(cfg_count);
      found = 1'b0;
      pick = 0;
      pick_size = '0;
      for (i = 0; i < limit; i++) begin
         if (!part_used[i]) begin
            case (cfg_mode)
               MODE_WORST: begin
                  if (!found || part_size[i] > pick_size) begin
                     found = 1'b1;
                     pick = i;
                     pick_size = part_size[i];
                  end
               end
               MODE_BEST: begin
                  if (part_size[i] >= need && (!found || part_size[i] < pick_size)) begin
                     found = 1'b1;
                     pick = i;
                     pick_size = part_size[i];
                  end
               end
               MODE_FIRST: begin
                  if (part_size[i] >= need && !found) begin
                     found = 1'b1;
                     pick = i;
                     pick_size = part_size[i];
                  end
               end
               default: ;
            endcase
         end
      end
      if (found && pick_size >= need) begin
         part_used[pick] = 1'b1;
         if (grant_total != COUNT_MAX)
            grant_total = grant_total + 1'b1;
         res.granted = 1'b1;
         res.chosen_block = pick[BIDX_W-1:0];
         res.owner_process = pid;
      end else begin
         res.granted = 1'b0;
         res.chosen_block = '0;
         res.owner_process = '0;
      end
      res.allocated_count = grant_total;
      return res;
   endfunction

   // directed table builders
   function automatic void add_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.reg_index = idx;
      r.reg_value = val;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_load(logic [BIDX_W-1:0] idx, logic [RSIZE_W-1:0] size,
                                    logic [PID_W-1:0] pid);
      stim_row_type r;
      r = '0;
      r.item = '{CMD_LOAD, idx, size, pid};
      directed_rows.push_back(r);
   endfunction

   function automatic void add_request(logic [RSIZE_W-1:0] size, logic [PID_W-1:0] pid);
      stim_row_type r;
      r = '0;
      r.item = '{CMD_REQUEST, ~pid, size, pid};
      directed_rows.push_back(r);
   endfunction

   function automatic void add_checked(logic [RSIZE_W-1:0] size, logic [PID_W-1:0] pid,
                                       logic g, logic [BIDX_W-1:0] blk,
                                       logic [PID_W-1:0] own, logic [COUNT_W-1:0] cnt);
      stim_row_type r;
      r = '0;
      r.item = '{CMD_REQUEST, pid, size, pid};
      r.literal_check = 1'b1;
      r.literal_result = '{g, blk, own, cnt};
      directed_rows.push_back(r);
   endfunction

   function automatic void build_directed_rows();
      add_write(CSR_BLOCK_COUNT, 7'd4);
      add_load(6'd0, 16'd0, 6'd0);
      add_load(6'd1, 16'd300, 6'd63);
      add_load(6'd2, 16'd200, 6'd21);
      add_load(6'd3, 16'd300, 6'd42);
      // worst fit: tie between partitions 1 and 3 goes to the lower index
      add_checked(16'd0, 6'd63, 1'b1, 6'd1, 6'd63, 7'd1);
      // worst fit: largest free partition too small
      add_checked(16'd301, 6'd1, 1'b0, 6'd0, 6'd0, 7'd1);
      add_checked(16'd300, 6'd2, 1'b1, 6'd3, 6'd2, 7'd2);
      add_write(CSR_FIT_MODE, 7'(MODE_BEST));
      add_load(6'd1, 16'd250, 6'd7);
      add_request(16'd150, 6'd8);
      // best fit: nothing fits, must refuse
      add_checked(16'd251, 6'd9, 1'b0, 6'd0, 6'd0, 7'd3);
      // zero-size partition taken by a zero-size request
      add_request(16'd0, 6'd10);
      add_write(CSR_FIT_MODE, 7'(MODE_FIRST));
      add_load(6'd0, 16'hFFFF, 6'd33);
      add_load(6'd2, 16'hFFFF, 6'd62);
      add_load(6'd3, 16'd10, 6'd17);
      add_request(16'hFFFF, 6'd0);
      add_request(16'd5, 6'd11);
      add_request(16'hFFFF, 6'd12);
      // unknown policy refuses everything
      add_write(CSR_FIT_MODE, 7'(MODE_NONE));
      add_load(6'd0, 16'd1, 6'd5);
      add_request(16'd0, 6'd13);
      // no partition in use
      add_write(CSR_FIT_MODE, 7'(MODE_FIRST));
      add_write(CSR_BLOCK_COUNT, 7'd0);
      add_request(16'd0, 6'd14);
   endfunction

   // gap length: mostly short, a few long
   function automatic int short_or_long_gap();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic int sender_gap();
      if (calm || $urandom_range(0, 99) < 60)
         return 0;
      return short_or_long_gap();
   endfunction

   function automatic logic [RSIZE_W-1:0] random_size();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      if (r < 7)
         return RSIZE_W'($urandom_range(0, 31));
      return RSIZE_W'($urandom);
   endfunction

   // called and returning at a falling edge
   task automatic offer_transaction(alloc_item_type it, int gap, bit use_literal,
                                    placement_type literal);
      placement_type res;
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.command = it.command;
      req_if.block_index = it.block_index;
      req_if.request_size = it.request_size;
      req_if.process_id = it.process_id;
      do
         @(posedge clock);
      while (!req_if.ready);
      if (it.command == CMD_LOAD) begin
         part_size[it.block_index] = it.request_size;
         part_used[it.block_index] = 1'b0;
         part_written[it.block_index] = 1'b1;
         n_loads++;
      end else begin
         res = predict_placement(it.request_size, it.process_id);
         expected_placements.push_back(use_literal ? literal : res);
         n_requests++;
      end
      @(negedge clock);
   endtask

   // wait until the block has nothing left in flight
   task automatic settle_block();
      req_if.valid = 1'b0;
      while (expected_placements.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = val;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == CSR_FIT_MODE)
         cfg_mode = val[MODE_W-1:0];
      else
         cfg_count = val[6:0];
   endtask

   // receiver: random stalls, one long hold-off to back the block up
   initial begin
      rsp_if.ready = 1'b0;
      stall_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            stall_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 99) < 15) begin
            rsp_if.ready = 1'b0;
            stall_left = short_or_long_gap() - 1;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      placement_type got;
      placement_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         got = '{rsp_if.granted, rsp_if.chosen_block, rsp_if.owner_process,
                 rsp_if.allocated_count};
         if (got.granted)
            n_granted++;
         if (expected_placements.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response: granted %0b block %0d owner %0d count %0d",
                        got.granted, got.chosen_block, got.owner_process,
                        got.allocated_count);
         end else begin
            want = expected_placements.pop_front();
            if (got.granted !== want.granted || got.chosen_block !== want.chosen_block ||
                got.owner_process !== want.owner_process ||
                got.allocated_count !== want.allocated_count) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"mismatch on response %0d (expected/actual): granted %0b/%0b",
                            " block %0d/%0d owner %0d/%0d count %0d/%0d"},
                           results_seen, want.granted, got.granted, want.chosen_block,
                           got.chosen_block, want.owner_process, got.owner_process,
                           want.allocated_count, got.allocated_count);
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no transaction accepted for %0d cycles", STALL_LIMIT);
      $display("FAIL fixed_partition_fit_allocator");
      $finish;
   end

   // main stimulus
   initial begin
      int             p;
      int             n;
      int             limit;
      int             hole;
      int             i;
      logic [MODE_W-1:0] mode;
      logic [6:0]     count;
      alloc_item_type it;
      stim_row_type   row;

      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.command = CMD_LOAD;
      req_if.block_index = '0;
      req_if.request_size = '0;
      req_if.process_id = '0;
      for (i = 0; i < NUM_PARTS; i++) begin
         part_size[i] = '0;
         part_used[i] = 1'b0;
         part_written[i] = 1'b0;
      end
      grant_total = '0;
      cfg_mode = MODE_WORST;
      cfg_count = 7'd64;
      fail_count = 0;
      results_seen = 0;
      n_loads = 0;
      n_requests = 0;
      n_granted = 0;
      n_settings = 0;
      calm = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      build_directed_rows();
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.is_write) begin
            settle_block();
            write_register(row.reg_index, row.reg_value);
            n_settings++;
         end else begin
            offer_transaction(row.item, sender_gap(), row.literal_check, row.literal_result);
         end
      end

      // random phases, each under its own policy and partition count
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin mode = MODE_WORST; count = 7'd64;  end
            1: begin mode = MODE_BEST;  count = 7'd1;   end
            2: begin mode = MODE_FIRST; count = 7'd127; end
            3: begin mode = MODE_NONE;  count = 7'd10;  end
            4: begin mode = MODE_BEST;  count = 7'd64;  end
            5: begin mode = MODE_WORST; count = 7'd0;   end
            6: begin mode = MODE_FIRST; count = 7'd8;   end
            7: begin mode = MODE_BEST;  count = 7'd100; end
            8: begin mode = MODE_WORST; count = 7'd1;   end
            9: begin mode = MODE_FIRST; count = 7'd65;  end
            default: begin
               mode = MODE_W'($urandom_range(0, 3));
               count = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(1, 16));
            end
         endcase
         settle_block();
         write_register(CSR_FIT_MODE, 7'(mode));
         write_register(CSR_BLOCK_COUNT, count);
         n_settings++;
         calm = (p % 5 == 3);
         limit = (count > NUM_PARTS) ? NUM_PARTS : int'(count);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // fill any never-loaded partition in range before requesting
            hole = -1;
            for (i = 0; i < limit && hole < 0; i++)
               if (!part_written[i])
                  hole = i;
            it.process_id = PID_W'($urandom);
            it.request_size = random_size();
            it.block_index = BIDX_W'($urandom);
            if (hole >= 0) begin
               it.command = CMD_LOAD;
               it.block_index = hole[BIDX_W-1:0];
            end else if ($urandom_range(0, 99) < 55) begin
               it.command = CMD_REQUEST;
            end else begin
               it.command = CMD_LOAD;
               if (limit > 0 && $urandom_range(0, 99) < 85)
                  it.block_index = BIDX_W'($urandom_range(0, limit - 1));
            end
            offer_transaction(it, sender_gap(), 1'b0, '0);
         end
      end

      // drain
      req_if.valid = 1'b0;
      while (expected_placements.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads and %0d requests under %0d register settings",
               n_loads, n_requests, n_settings);
      $display("%0d requests granted, %0d refused, %0d mismatches",
               n_granted, results_seen - n_granted, fail_count);
      if (fail_count == 0)
         $display("PASS fixed_partition_fit_allocator");
      else
         $display("FAIL fixed_partition_fit_allocator");
      $finish;
   end

endmodule

// ===== fixed_partition_fit_allocator.f =====
rtl/fpfa_pkg.sv
rtl/fpfa_if.sv
rtl/fpfa_mem.sv
rtl/fpfa_scan.sv
rtl/fixed_partition_fit_allocator.sv
verif/fixed_partition_fit_allocator_tb.sv
